### rtl/sled_pkg.sv
package sled_pkg;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [1:0] ST_VALUE  = 2'd0;
    localparam logic [1:0] ST_CLOSED = 2'd1;
    localparam logic [1:0] ST_BADHEX = 2'd2;
    localparam logic [1:0] ST_UNTERM = 2'd3;

    localparam logic [1:0] FORM_NONE = 2'd0;
    localparam logic [1:0] FORM_X    = 2'd1;
    localparam logic [1:0] FORM_U    = 2'd2;
    localparam logic [1:0] FORM_BIGU = 2'd3;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;

    typedef enum logic [2:0] {
        PH_BODY = 3'b001,
        PH_ESC  = 3'b010,
        PH_HEX  = 3'b100
    } phase_t;

    // results caused by one item; last_idx is the result count minus one
    typedef struct packed {
        logic [1:0]      last_idx;
        logic [1:0]      status;
        logic [3:0][7:0] bytes;
    } grp_t;

    typedef struct packed {
        logic valid;
        grp_t grp;
    } push_t;

    // {ok, value}
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c inside {[8'h30:8'h39]})
        begin
            r = {1'b1, c[3:0]};
        end
        else if (c inside {[8'h61:8'h66], [8'h41:8'h46]})
        begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

endpackage

### rtl/string_literal_escape_decoder_core.sv
// String literal escape decoder.
// Slave channel s_*: one source byte of the literal body per item; tuser selects the
// closing quote (0 double, 1 single), tlast marks the end of source (tdata ignored).
// Master channel m_*: one decoded result per item; tdata is the value byte, tuser the
// status (value, closed, bad hex digit, unterminated), tlast marks the last result
// caused by one input item. An input item gives zero to four results.
// With an empty result queue, the first result of an item reaches m_* through the
// input register, then the result queue.
// Throughput: one input item per cycle while items give at most one result each and
// m_tready stays high; a multi-byte UTF-8 sequence holds the output for one result
// per byte, and a four-entry result queue absorbs the bursts before s_tready drops.
// Reset: decoder state returns to the literal body outside any escape, the input
// register and the result queue are emptied.
// When the receiver stalls, results stay in the queue; s_tready falls once the queue
// and the input register are full, and resumes as soon as a queue entry frees.
module string_literal_escape_decoder_core
    import sled_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // in_byte
    input  logic       s_tuser,    // quote_kind
    input  logic       s_tlast,    // source_end
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // out_byte
    output logic [1:0] m_tuser,    // status
    output logic       m_tlast     // last
);

    push_t push;
    logic  q_full;

    sled_decode u_decode (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .push     (push)
    );

    sled_outq u_outq (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .q_full   (q_full),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

### rtl/sled_decode.sv
module sled_decode
    import sled_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // in_byte
    input  logic       s_tuser,    // quote_kind
    input  logic       s_tlast,    // source_end
    input  logic       q_full,
    output push_t      push
);

    localparam logic [7:0] CH_N  = 8'h6E;
    localparam logic [7:0] CH_T  = 8'h74;
    localparam logic [7:0] CH_R  = 8'h72;
    localparam logic [7:0] CH_A  = 8'h61;
    localparam logic [7:0] CH_B  = 8'h62;
    localparam logic [7:0] CH_F  = 8'h66;
    localparam logic [7:0] CH_V  = 8'h76;
    localparam logic [7:0] CH_0  = 8'h30;
    localparam logic [7:0] CH_X  = 8'h78;
    localparam logic [7:0] CH_U  = 8'h75;
    localparam logic [7:0] CH_BU = 8'h55;

    logic        in_vld_reg;
    logic [7:0]  byte_reg;
    logic        qkind_reg;
    logic        send_reg;

    phase_t      phase_reg, phase_next;
    logic [1:0]  form_reg, form_next;
    logic [3:0]  digits_reg, digits_next;
    logic [31:0] accum_reg, accum_next;

    logic        advance;
    logic        s_acc;
    logic [7:0]  quote;
    logic [4:0]  dig;
    logic [31:0] cp;
    logic [3:0]  digits_inc;
    logic [3:0]  need;
    grp_t        grp;
    logic        has;

    assign advance  = in_vld_reg && !q_full;
    assign s_tready = !in_vld_reg || !q_full;
    assign s_acc    = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (s_acc)
        begin
            in_vld_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            byte_reg  <= s_tdata;
            qkind_reg <= s_tuser;
            send_reg  <= s_tlast;
        end
    end

    assign quote      = qkind_reg ? CH_SQUOTE : CH_DQUOTE;
    assign dig        = hex_digit(byte_reg);
    assign cp         = {accum_reg[27:0], dig[3:0]};
    assign digits_inc = digits_reg + 4'd1;
    assign need       = (form_reg == FORM_X) ? 4'd2 : (form_reg == FORM_U) ? 4'd4 : 4'd8;

    always_comb
    begin
        phase_next  = phase_reg;
        form_next   = form_reg;
        digits_next = digits_reg;
        accum_next  = accum_reg;
        has         = 1'b0;
        grp         = '0;
        grp.status  = ST_VALUE;
        if (send_reg)
        begin
            phase_next  = PH_BODY;
            form_next   = FORM_NONE;
            digits_next = '0;
            accum_next  = '0;
            has         = 1'b1;
            grp.status  = ST_UNTERM;
        end
        else
        begin
            case (phase_reg)
                PH_ESC:
                begin
                    phase_next = PH_BODY;
                    has        = 1'b1;
                    case (byte_reg)
                        CH_N:      grp.bytes[0] = 8'h0A;
                        CH_T:      grp.bytes[0] = 8'h09;
                        CH_R:      grp.bytes[0] = 8'h0D;
                        CH_BSLASH: grp.bytes[0] = CH_BSLASH;
                        CH_DQUOTE: grp.bytes[0] = CH_DQUOTE;
                        CH_SQUOTE: grp.bytes[0] = CH_SQUOTE;
                        CH_A:      grp.bytes[0] = 8'h07;
                        CH_B:      grp.bytes[0] = 8'h08;
                        CH_F:      grp.bytes[0] = 8'h0C;
                        CH_V:      grp.bytes[0] = 8'h0B;
                        CH_0:      grp.bytes[0] = 8'h00;
                        CH_X, CH_U, CH_BU:
                        begin
                            has         = 1'b0;
                            phase_next  = PH_HEX;
                            digits_next = '0;
                            accum_next  = '0;
                            form_next   = (byte_reg == CH_X) ? FORM_X :
                                          (byte_reg == CH_U) ? FORM_U : FORM_BIGU;
                        end
                        default:
                        begin
                            grp.last_idx = 2'd1;
                            grp.bytes[0] = CH_BSLASH;
                            grp.bytes[1] = byte_reg;
                        end
                    endcase
                end
                PH_HEX:
                begin
                    if (!dig[4])
                    begin
                        phase_next  = PH_BODY;
                        form_next   = FORM_NONE;
                        digits_next = '0;
                        accum_next  = '0;
                        has         = 1'b1;
                        grp.status  = ST_BADHEX;
                    end
                    else if (digits_inc < need)
                    begin
                        accum_next  = cp;
                        digits_next = digits_inc;
                    end
                    else
                    begin
                        phase_next  = PH_BODY;
                        form_next   = FORM_NONE;
                        digits_next = '0;
                        accum_next  = '0;
                        has         = 1'b1;
                        if (form_reg == FORM_X || cp <= 32'h7F)
                        begin
                            grp.bytes[0] = cp[7:0];
                        end
                        else if (cp <= 32'h7FF)
                        begin
                            grp.last_idx = 2'd1;
                            grp.bytes[0] = {3'b110, cp[10:6]};
                            grp.bytes[1] = {2'b10, cp[5:0]};
                        end
                        else if (cp <= 32'hFFFF)
                        begin
                            grp.last_idx = 2'd2;
                            grp.bytes[0] = {4'b1110, cp[15:12]};
                            grp.bytes[1] = {2'b10, cp[11:6]};
                            grp.bytes[2] = {2'b10, cp[5:0]};
                        end
                        else if (cp <= 32'h10FFFF)
                        begin
                            grp.last_idx = 2'd3;
                            grp.bytes[0] = {5'b11110, cp[20:18]};
                            grp.bytes[1] = {2'b10, cp[17:12]};
                            grp.bytes[2] = {2'b10, cp[11:6]};
                            grp.bytes[3] = {2'b10, cp[5:0]};
                        end
                        else
                        begin
                            has = 1'b0;
                        end
                    end
                end
                default:
                begin
                    if (byte_reg == quote)
                    begin
                        phase_next  = PH_BODY;
                        form_next   = FORM_NONE;
                        digits_next = '0;
                        accum_next  = '0;
                        has         = 1'b1;
                        grp.status  = ST_CLOSED;
                    end
                    else if (byte_reg == CH_BSLASH)
                    begin
                        phase_next = PH_ESC;
                    end
                    else
                    begin
                        has          = 1'b1;
                        grp.bytes[0] = byte_reg;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_BODY;
            form_reg   <= FORM_NONE;
            digits_reg <= '0;
            accum_reg  <= '0;
        end
        else if (advance)
        begin
            phase_reg  <= phase_next;
            form_reg   <= form_next;
            digits_reg <= digits_next;
            accum_reg  <= accum_next;
        end
    end

    assign push.valid = advance && has;
    assign push.grp   = grp;

    a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && send_reg) |=> (phase_reg == PH_BODY && digits_reg == 4'd0))
        else $error("source end did not return to idle");

    a_hex_digits: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_HEX) |-> (digits_reg < need && form_reg != FORM_NONE))
        else $error("hex digit count out of range");

endmodule

### rtl/sled_outq.sv
module sled_outq
    import sled_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  push_t      push,
    output logic       q_full,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // out_byte
    output logic [1:0] m_tuser,    // status
    output logic       m_tlast     // last
);

    grp_t              q_mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg;
    logic [1:0]        sub_reg;
    grp_t              head;
    logic              pop;
    logic              m_acc;

    assign q_full   = (cnt_reg == QCNT_W'(QDEPTH));
    assign head     = q_mem[rd_ptr_reg];
    assign m_tvalid = (cnt_reg != '0);
    assign m_acc    = m_tvalid && m_tready;
    assign m_tlast  = (sub_reg == head.last_idx);
    assign pop      = m_acc && m_tlast;
    assign m_tdata  = head.bytes[sub_reg];
    assign m_tuser  = head.status;

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            q_mem[wr_ptr_reg] <= push.grp;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
            sub_reg    <= '0;
        end
        else
        begin
            if (push.valid)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
                sub_reg    <= '0;
            end
            else if (m_acc)
            begin
                sub_reg <= sub_reg + 2'd1;
            end
            if (push.valid && !pop)
            begin
                cnt_reg <= cnt_reg + QCNT_W'(1);
            end
            else if (pop && !push.valid)
            begin
                cnt_reg <= cnt_reg - QCNT_W'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push.valid && q_full))
        else $error("push into full queue");

    a_sub_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (sub_reg <= head.last_idx))
        else $error("result index past group end");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg <= QCNT_W'(QDEPTH)) && ((cnt_reg != '0) || (sub_reg == 2'd0)))
        else $error("queue count out of range");

endmodule

### dv/tb_string_literal_escape_decoder_core.sv
`timescale 1ns / 100ps

module tb_string_literal_escape_decoder_core
    import sled_pkg::*;
();

    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_ITEMS = 195;

    typedef struct {
        logic [7:0] value;
        logic [1:0] status;
        logic       last;
    } dec_result_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       s_tuser;
    logic       s_tlast;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic [1:0] m_tuser;
    logic       m_tlast;

    // decoder state as predicted
    phase_t      dec_phase;
    logic [1:0]  dec_form;
    logic [3:0]  dec_digits;
    logic [31:0] dec_code;

    dec_result_t decoded_q[$];
    dec_result_t mon_exp;

    int   err_cnt = 0;
    int   items_sent = 0;
    int   cycles = 0;
    bit   tx_steady = 1'b0;
    bit   rx_steady = 1'b0;
    int   rx_draw;
    logic [3:0] rx_hold;
    logic lit_kind;

    string_literal_escape_decoder_core i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results pending", cycles, decoded_q.size());
            $display("simulation failed");
            $finish;
        end
    end

    // receiver: random stall after each result
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            rx_hold  <= 4'd0;
        end
        else if (m_tready)
        begin
            if (m_tvalid)
            begin
                rx_draw = rx_steady ? 0 : $urandom_range(0, 14);
                if (rx_draw != 0)
                begin
                    m_tready <= 1'b0;
                    rx_hold  <= 4'(rx_draw);
                end
            end
        end
        else if (rx_hold <= 4'd1)
        begin
            m_tready <= 1'b1;
        end
        else
        begin
            rx_hold <= rx_hold - 4'd1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (decoded_q.size() == 0)
            begin
                if (err_cnt < 10)
                    $display("unexpected result: value %h status %0d last %0d",
                             m_tdata, m_tuser, m_tlast);
                err_cnt++;
            end
            else
            begin
                mon_exp = decoded_q.pop_front();
                if ({m_tdata, m_tuser, m_tlast} !== {mon_exp.value, mon_exp.status, mon_exp.last})
                begin
                    if (err_cnt < 10)
                        $display("mismatch: expected value %h status %0d last %0d, got %h %0d %0d",
                                 mon_exp.value, mon_exp.status, mon_exp.last,
                                 m_tdata, m_tuser, m_tlast);
                    err_cnt++;
                end
            end
        end
    end

    function automatic void decoder_idle();
        dec_phase  = PH_BODY;
        dec_form   = FORM_NONE;
        dec_digits = 4'd0;
        dec_code   = 32'd0;
    endfunction

    function automatic int hex_nibble(input logic [7:0] c);
        if (c inside {[8'h30:8'h39]})
            return int'(c - 8'h30);
        if (c inside {[8'h61:8'h66]})
            return int'(c - 8'h61) + 10;
        if (c inside {[8'h41:8'h46]})
            return int'(c - 8'h41) + 10;
        return -1;
    endfunction

    function automatic void decode_byte(input logic [7:0] c, input logic kind,
                                        input logic src_end);
        logic [7:0]  vals [4];
        logic [1:0]  st;
        logic [7:0]  qch;
        logic [3:0]  need;
        logic [31:0] cp;
        logic [1:0]  fm;
        dec_result_t r;
        int          n;
        int          d;
        int          i;
        n   = 0;
        st  = ST_VALUE;
        qch = kind ? CH_SQUOTE : CH_DQUOTE;
        for (i = 0; i < 4; i++)
            vals[i] = 8'h00;
        if (src_end)
        begin
            decoder_idle();
            st = ST_UNTERM;
            n  = 1;
        end
        else if (dec_phase == PH_ESC)
        begin
            dec_phase = PH_BODY;
            n = 1;
            case (c)
                8'h6E: vals[0] = 8'h0A;
                8'h74: vals[0] = 8'h09;
                8'h72: vals[0] = 8'h0D;
                8'h5C: vals[0] = 8'h5C;
                8'h22: vals[0] = 8'h22;
                8'h27: vals[0] = 8'h27;
                8'h61: vals[0] = 8'h07;
                8'h62: vals[0] = 8'h08;
                8'h66: vals[0] = 8'h0C;
                8'h76: vals[0] = 8'h0B;
                8'h30: vals[0] = 8'h00;
                8'h78, 8'h75, 8'h55:
                begin
                    dec_form   = (c == 8'h78) ? FORM_X : (c == 8'h75) ? FORM_U : FORM_BIGU;
                    dec_phase  = PH_HEX;
                    dec_digits = 4'd0;
                    dec_code   = 32'd0;
                    n = 0;
                end
                default:
                begin
                    vals[0] = CH_BSLASH;
                    vals[1] = c;
                    n = 2;
                end
            endcase
        end
        else if (dec_phase == PH_HEX)
        begin
            d = hex_nibble(c);
            if (d < 0)
            begin
                decoder_idle();
                st = ST_BADHEX;
                n  = 1;
            end
            else
            begin
                dec_code   = {dec_code[27:0], d[3:0]};
                dec_digits = dec_digits + 4'd1;
                need = (dec_form == FORM_X) ? 4'd2 : (dec_form == FORM_U) ? 4'd4 : 4'd8;
                if (dec_digits >= need)
                begin
                    cp = dec_code;
                    fm = dec_form;
                    decoder_idle();
                    if (fm == FORM_X)
                    begin
                        vals[0] = cp[7:0];
                        n = 1;
                    end
                    else if (cp <= 32'h7F)
                    begin
                        vals[0] = cp[7:0];
                        n = 1;
                    end
                    else if (cp <= 32'h7FF)
                    begin
                        vals[0] = 8'hC0 | {3'd0, cp[10:6]};
                        vals[1] = 8'h80 | {2'd0, cp[5:0]};
                        n = 2;
                    end
                    else if (cp <= 32'hFFFF)
                    begin
                        vals[0] = 8'hE0 | {4'd0, cp[15:12]};
                        vals[1] = 8'h80 | {2'd0, cp[11:6]};
                        vals[2] = 8'h80 | {2'd0, cp[5:0]};
                        n = 3;
                    end
                    else if (cp <= 32'h10FFFF)
                    begin
                        vals[0] = 8'hF0 | {5'd0, cp[20:18]};
                        vals[1] = 8'h80 | {2'd0, cp[17:12]};
                        vals[2] = 8'h80 | {2'd0, cp[11:6]};
                        vals[3] = 8'h80 | {2'd0, cp[5:0]};
                        n = 4;
                    end
                end
            end
        end
        else
        begin
            if (c == qch)
            begin
                decoder_idle();
                st = ST_CLOSED;
                n  = 1;
            end
            else if (c == CH_BSLASH)
            begin
                dec_phase = PH_ESC;
            end
            else
            begin
                vals[0] = c;
                n = 1;
            end
        end
        for (i = 0; i < n; i++)
        begin
            r.value  = vals[i];
            r.status = st;
            r.last   = (i == n - 1);
            decoded_q = {decoded_q, r};
        end
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10)
            return 8'h30 + {4'd0, nib};
        return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + {4'd0, nib} - 8'd10;
    endfunction

    function automatic logic [7:0] non_hex_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        while (hex_nibble(b) >= 0)
            b = 8'($urandom_range(0, 255));
        return b;
    endfunction

    task automatic send_item(input logic [7:0] b, input logic kind, input logic src_end);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 14);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= kind;
        s_tlast  <= src_end;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        decode_byte(b, kind, src_end);
        items_sent++;
    endtask

    // hex digits of an escape, most significant first; break_sel 0..1 puts a bad
    // digit at position pos, 2 ends the source there, anything else runs clean
    task automatic send_hex_run(input logic [31:0] value, input int ndig,
                                input int break_sel, input int pos, output bit broken);
        int i;
        broken = 1'b0;
        for (i = ndig - 1; i >= 0 && !broken; i--)
        begin
            if (break_sel < 3 && i == pos)
            begin
                if (break_sel == 2)
                    send_item(8'($urandom_range(0, 255)), lit_kind, 1'b1);
                else
                    send_item(non_hex_byte(), lit_kind, 1'b0);
                broken = 1'b1;
            end
            else
            begin
                send_item(hex_char(value[4*i +: 4]), lit_kind, 1'b0);
            end
        end
    endtask

    task automatic test_passthrough();
        lit_kind = 1'b0;
        send_item(8'h00, lit_kind, 1'b0);
        send_item(8'hFF, lit_kind, 1'b0);
        send_item(8'h24, lit_kind, 1'b0);
        send_item(CH_SQUOTE, lit_kind, 1'b0);
        send_item(CH_DQUOTE, lit_kind, 1'b0);
    endtask

    task automatic test_escapes();
        lit_kind = 1'b1;
        send_item(CH_BSLASH, lit_kind, 1'b0);
        send_item(8'h71, lit_kind, 1'b0);
        send_item(CH_BSLASH, lit_kind, 1'b0);
        send_item(8'h30, lit_kind, 1'b0);
        send_item(CH_BSLASH, lit_kind, 1'b0);
        send_item(CH_SQUOTE, lit_kind, 1'b0);
        send_item(CH_SQUOTE, lit_kind, 1'b0);
    endtask

    task automatic test_hex_escapes();
        bit broken;
        lit_kind = 1'b0;
        send_item(CH_BSLASH, lit_kind, 1'b0);
        send_item(8'h78, lit_kind, 1'b0);
        send_item(8'h66, lit_kind, 1'b0);
        send_item(8'h41, lit_kind, 1'b0);
        // beyond the last code point: no output
        send_item(CH_BSLASH, lit_kind, 1'b0);
        send_item(8'h55, lit_kind, 1'b0);
        send_hex_run(32'h0011_0000, 8, 3, 0, broken);
        send_item(CH_DQUOTE, lit_kind, 1'b0);
    endtask

    task automatic test_abort_cases();
        lit_kind = 1'b0;
        send_item(CH_BSLASH, lit_kind, 1'b0);
        send_item(8'h75, lit_kind, 1'b0);
        send_item(8'h31, lit_kind, 1'b0);
        send_item(8'h5A, lit_kind, 1'b0);
        send_item(CH_BSLASH, lit_kind, 1'b0);
        send_item(8'h55, lit_kind, 1'b0);
        send_item(8'hFF, lit_kind, 1'b1);
        send_item(8'h00, lit_kind, 1'b1);
    endtask

    task automatic send_element(output bit broken);
        logic [7:0]  plain;
        logic [7:0]  simple_esc [11];
        logic [31:0] cp;
        int          sel;
        simple_esc = '{8'h6E, 8'h74, 8'h72, 8'h5C, 8'h22, 8'h27,
                       8'h61, 8'h62, 8'h66, 8'h76, 8'h30};
        broken = 1'b0;
        sel = $urandom_range(0, 9);
        if (sel <= 2)
        begin
            plain = 8'($urandom_range(0, 255));
            if (plain == CH_BSLASH || plain == (lit_kind ? CH_SQUOTE : CH_DQUOTE))
                plain = plain ^ 8'h01;
            send_item(plain, lit_kind, 1'b0);
        end
        else if (sel <= 4)
        begin
            send_item(CH_BSLASH, lit_kind, 1'b0);
            send_item(simple_esc[$urandom_range(0, 10)], lit_kind, 1'b0);
        end
        else if (sel == 5)
        begin
            send_item(CH_BSLASH, lit_kind, 1'b0);
            if ($urandom_range(0, 9) == 0)
            begin
                send_item(8'($urandom_range(0, 255)), lit_kind, 1'b1);
                broken = 1'b1;
            end
            else
            begin
                send_item(8'($urandom_range(0, 255)), lit_kind, 1'b0);
            end
        end
        else if (sel == 6)
        begin
            send_item(CH_BSLASH, lit_kind, 1'b0);
            send_item(8'h78, lit_kind, 1'b0);
            send_hex_run(32'($urandom_range(0, 255)), 2, $urandom_range(0, 19),
                         $urandom_range(0, 1), broken);
        end
        else if (sel == 7)
        begin
            case ($urandom_range(0, 6))
                0: cp = $urandom_range(0, 32'h7F);
                1: cp = $urandom_range(32'h80, 32'h7FF);
                2: cp = $urandom_range(32'h800, 32'hFFFF);
                3: cp = $urandom_range(32'hD800, 32'hDFFF);
                4:
                begin
                    case ($urandom_range(0, 5))
                        0: cp = 32'h0;
                        1: cp = 32'h7F;
                        2: cp = 32'h80;
                        3: cp = 32'h7FF;
                        4: cp = 32'h800;
                        default: cp = 32'hFFFF;
                    endcase
                end
                default: cp = $urandom_range(0, 32'hFFFF);
            endcase
            send_item(CH_BSLASH, lit_kind, 1'b0);
            send_item(8'h75, lit_kind, 1'b0);
            send_hex_run(cp, 4, $urandom_range(0, 19), $urandom_range(0, 3), broken);
        end
        else
        begin
            case ($urandom_range(0, 6))
                0: cp = $urandom_range(0, 32'h7F);
                1: cp = $urandom_range(32'h80, 32'h7FF);
                2: cp = $urandom_range(32'h800, 32'hFFFF);
                3: cp = $urandom_range(32'h10000, 32'h10FFFF);
                4: cp = $urandom_range(32'h110000, 32'hFFFFFFFF);
                5:
                begin
                    case ($urandom_range(0, 4))
                        0: cp = 32'h10000;
                        1: cp = 32'h10FFFF;
                        2: cp = 32'h110000;
                        3: cp = 32'hFFFFFFFF;
                        default: cp = 32'h0;
                    endcase
                end
                default: cp = $urandom();
            endcase
            send_item(CH_BSLASH, lit_kind, 1'b0);
            send_item(8'h55, lit_kind, 1'b0);
            send_hex_run(cp, 8, $urandom_range(0, 19), $urandom_range(0, 7), broken);
        end
    endtask

    task automatic send_literal();
        int  n_elem;
        int  i;
        int  sel;
        bit  broken;
        lit_kind = 1'($urandom_range(0, 1));
        n_elem = $urandom_range(1, 6);
        broken = 1'b0;
        for (i = 0; i < n_elem && !broken; i++)
            send_element(broken);
        if (!broken)
        begin
            sel = $urandom_range(0, 9);
            if (sel < 7)
                send_item(lit_kind ? CH_SQUOTE : CH_DQUOTE, lit_kind, 1'b0);
            else if (sel == 7)
                send_item(8'($urandom_range(0, 255)), lit_kind, 1'b1);
        end
    endtask

    task automatic send_noise();
        int n;
        int i;
        n = $urandom_range(1, 4);
        for (i = 0; i < n; i++)
            send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      $urandom_range(0, 7) == 0);
    endtask

    task automatic test_random_literals();
        int stop_at;
        stop_at = items_sent + RANDOM_ITEMS;
        while (items_sent < stop_at)
        begin
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 7) == 0)
                send_noise();
            else
                send_literal();
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    initial
    begin
        s_tvalid = 1'b0;
        s_tdata  = 8'h00;
        s_tuser  = 1'b0;
        s_tlast  = 1'b0;
        rst_n    = 1'b0;
        lit_kind = 1'b0;
        decoder_idle();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_passthrough();
        test_escapes();
        test_hex_escapes();
        test_abort_cases();
        test_random_literals();

        s_tvalid <= 1'b0;
        while (decoded_q.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (err_cnt == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
